// ===== rtl/core/double_ended_queue_top_assert.svh =====
// Assertion macros used by the deque datapath.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

// ===== rtl/core/deq_pkg.sv =====
// Package with the deque's payload types, codes and controller types.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W   = 5;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      command_type               command;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      status_type                status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_payload_type;

   // Controller states
   typedef enum logic [1:0] {
      CS_IDLE,
      CS_EXEC,
      CS_READ
   } ctl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_pop;
   } deq_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pop_ok;
   } deq_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/deq_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface deq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/deq_dpath.sv =====
// Deque datapath: slot memory, head pointer, element count and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_top_assert.svh"
module deq_dpath
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_payload_type  req_payload,
   input  wire deq_cmd_type      cmd_i,
   output deq_sts_type           sts_o,
   output rsp_payload_type       rsp_payload
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   // Captured request
   command_type               cmd_ff;
   logic signed [VALUE_W-1:0] val_ff;

   // Ring state
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Slot memory and its read register
   logic [VALUE_W-1:0] slots_mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;

   // Result register
   logic signed [VALUE_W-1:0] popped_ff;
   status_type                status_ff;
   logic [OCC_W-1:0]          occ_ff;

   logic               full, empty;
   logic [PTR_W-1:0]   head_dec, head_inc;
   logic [SUM_W-1:0]   rear_sum, rear_last;
   logic [PTR_W-1:0]   push_pos, pop_pos;
   logic               wr_en, rd_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   status_type         res_status;

   // Ring position arithmetic, each wrap is one compare and subtract
   always_comb begin
      full      = (count_ff == DEPTH_CNT);
      empty     = (count_ff == '0);
      head_dec  = (head_ff == '0) ? LAST_PTR : head_ff - 1'b1;
      head_inc  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      rear_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      rear_last = rear_sum - 1'b1;
      push_pos  = (rear_sum >= DEPTH_SUM) ? PTR_W'(rear_sum - DEPTH_SUM)
                                          : PTR_W'(rear_sum);
      pop_pos   = (rear_last >= DEPTH_SUM) ? PTR_W'(rear_last - DEPTH_SUM)
                                           : PTR_W'(rear_last);
   end

   // Operation decode
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      wr_addr    = head_dec;
      rd_addr    = head_ff;
      res_status = STS_OK;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            if (full) begin
               res_status = STS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_REAR: begin
            if (full) begin
               res_status = STS_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = push_pos;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               res_status = STS_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_REAR: begin
            if (empty) begin
               res_status = STS_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = pop_pos;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            res_status = STS_OK;
         end
      endcase
   end

   assign sts_o.pop_ok = rd_en;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd_i.load_req) begin
         cmd_ff <= req_payload.command;
         val_ff <= req_payload.value;
      end
   end

   // Head and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd_i.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd_i.exec && wr_en) begin
         slots_mem[wr_addr] <= val_ff;
      end
      if (cmd_i.exec && rd_en) begin
         rdata_ff <= slots_mem[rd_addr];
      end
   end

   // Result register: pushes and refusals load at execute, pops after the read
   always_ff @(posedge clock) begin
      if (cmd_i.exec && !rd_en) begin
         popped_ff <= '0;
         status_ff <= res_status;
         occ_ff    <= OCC_W'(count_in);
      end else if (cmd_i.load_pop) begin
         popped_ff <= rdata_ff;
         status_ff <= STS_OK;
         occ_ff    <= OCC_W'(count_ff);
      end
   end

   assign rsp_payload.popped_value = popped_ff;
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.occupancy    = occ_ff;

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT)
   `DEQ_ASSERT_NOW(a_head_bound, clock, reset, 1'b1, head_ff <= LAST_PTR)
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset, cmd_i.exec && wr_en, count_ff == $past(count_ff) + 1'b1)
   `DEQ_ASSERT_NEXT(a_refused_holds, clock, reset, cmd_i.exec && (res_status != STS_OK), $stable(head_ff) && $stable(count_ff))

endmodule
`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// Deque controller: sequences request capture, execute, memory read and response.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl
   import deq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire deq_sts_type sts_i,
   output deq_cmd_type      cmd_o
);

   ctl_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;
   logic          out_set;

   // State and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      state_in  = state_ff;
      req_ready = 1'b0;
      out_set   = 1'b0;
      cmd_o     = '0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load_req = 1'b1;
               state_in       = CS_EXEC;
            end
         end
         CS_EXEC: begin
            // wait until the result register can take a new transaction
            if (out_free) begin
               cmd_o.exec = 1'b1;
               if (sts_i.pop_ok) begin
                  state_in = CS_READ;
               end else begin
                  out_set  = 1'b1;
                  state_in = CS_IDLE;
               end
            end
         end
         CS_READ: begin
            if (out_free) begin
               cmd_o.load_pop = 1'b1;
               out_set        = 1'b1;
               state_in       = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      out_valid_in = out_set || (out_valid_ff && !rsp_ready);
   end

   assign rsp_valid = out_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/double_ended_queue_top.sv =====
// Bounded deque of signed 32-bit words on a ring buffer: top level.
//
// Each request transaction carries a command (push front, push rear, pop
// front, pop rear) and a word; each one returns exactly one response with the
// popped word (zero unless a pop succeeded), a status (ok, full, empty) and
// the occupancy after the step, in request order. A push when full or a pop
// when empty is refused and leaves the queue unchanged. For pushes and refused
// operations the response is loaded at execute; for successful pops it is
// loaded in the read state after execute, because the slot memory has one
// registered read port. The controller handles one request at a time, so
// a new request is taken only once the last has left execute (pushes,
// refusals) or the read state (pops). A request is taken while an earlier
// response still waits; it then stalls at execute until that response leaves.
// Slot contents are not cleared at reset; only written slots are ever read.
// Occupancy is the element count truncated to 5 bits.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   deq_stream_if.sink   req_chan,
   deq_stream_if.source rsp_chan
);

   deq_cmd_type cmd;
   deq_sts_type sts;

   // Sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   // Storage and arithmetic
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .rsp_payload (rsp_chan.payload)
   );

endmodule
`default_nettype wire

// ===== dv/tb_double_ended_queue_top.sv =====
// Self-checking testbench for the ring-buffer deque top level.
`timescale 1ns / 1ps
module tb_double_ended_queue_top;
   import deq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int PTR_W        = $clog2(DEPTH);
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 120;
   localparam longint RUN_LIMIT_NS = 3_000_000;

   typedef struct {
      command_type     command;
      logic signed [VALUE_W-1:0] value;
      bit              typed;
      rsp_payload_type result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deq_stream_if #(.payload_type(req_payload_type)) req_if ();
   deq_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   double_ended_queue_top #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always #5 clock = ~clock;

   // Mirror of the deque contents
   logic signed [VALUE_W-1:0] mirror_slots [DEPTH];
   logic [PTR_W-1:0]          mirror_head  = '0;
   logic [OCC_W-1:0]          mirror_count = '0;

   directed_row_type  directed_rows[$];
   rsp_payload_type   awaited_results[$];
   int accepted_requests = 0;
   int checked_responses = 0;
   int mismatch_count    = 0;
   int pushes_stored     = 0;
   int pops_returned     = 0;
   int full_refusals     = 0;
   int empty_refusals    = 0;
   int hold_offs_done    = 0;

   // Apply one command to the mirror and return the response it should give
   function automatic rsp_payload_type deque_apply(req_payload_type item);
      rsp_payload_type  r;
      logic [PTR_W-1:0] slot_pos;
      r.popped_value = '0;
      r.status       = STS_OK;
      case (item.command)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (mirror_count == DEPTH) begin
               r.status = STS_FULL;
               full_refusals++;
            end else begin
               if (item.command == CMD_PUSH_FRONT) begin
                  mirror_head = mirror_head - 1'b1;
                  slot_pos    = mirror_head;
               end else begin
                  slot_pos = mirror_head + mirror_count[PTR_W-1:0];
               end
               mirror_slots[slot_pos] = item.value;
               mirror_count++;
               pushes_stored++;
            end
         end
         default: begin
            if (mirror_count == 0) begin
               r.status = STS_EMPTY;
               empty_refusals++;
            end else begin
               if (item.command == CMD_POP_FRONT) begin
                  slot_pos    = mirror_head;
                  mirror_head = mirror_head + 1'b1;
               end else begin
                  slot_pos = mirror_head + mirror_count[PTR_W-1:0] - 1'b1;
               end
               r.popped_value = mirror_slots[slot_pos];
               mirror_count--;
               pops_returned++;
            end
         end
      endcase
      r.occupancy = mirror_count;
      return r;
   endfunction

   function automatic void add_row(command_type command, logic signed [VALUE_W-1:0] value,
                                   bit typed = 1'b0, rsp_payload_type result = '0);
      directed_row_type row;
      row.command = command;
      row.value   = value;
      row.typed   = typed;
      row.result  = result;
      directed_rows.push_back(row);
   endfunction

   // Offer one transaction and hold it until the queue takes it
   task automatic offer_command(command_type command, logic signed [VALUE_W-1:0] value);
      req_payload_type item;
      item.command   = command;
      item.value     = value;
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Monitor: check responses in order, predict each accepted request
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (awaited_results.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected response: value %h status %0d occupancy %0d",
                           got.popped_value, got.status, got.occupancy);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (got.popped_value !== want.popped_value || got.status !== want.status ||
                   got.occupancy !== want.occupancy) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("response %0d mismatch: expected value %h status %0d occ %0d, %s",
                              checked_responses, want.popped_value, want.status,
                              want.occupancy,
                              $sformatf("got value %h status %0d occ %0d",
                                        got.popped_value, got.status, got.occupancy));
                  mismatch_count++;
               end
               checked_responses++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = deque_apply(req_if.payload);
            if (accepted_requests < directed_rows.size() &&
                directed_rows[accepted_requests].typed)
               want = directed_rows[accepted_requests].result;
            awaited_results.push_back(want);
            accepted_requests++;
         end
      end
   end

   // Response side: stall patterns, plus two long hold-offs that stall the request side
   initial begin : receiver
      int pattern;
      int stretch;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_offs_done < 2 && accepted_requests >= 300 + hold_offs_done * 900) begin
            hold_offs_done++;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_if.ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            pattern = $urandom_range(0, 3);
            stretch = $urandom_range(5, 40);
            for (int k = 0; k < stretch; k++) begin
               case (pattern)
                  0:       rsp_if.ready <= 1'b1;
                  1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                  2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_if.ready <= ((k % 4) != 3);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Request side: directed table, then random bursts
   initial begin : sender
      int phase_left;
      int push_pct;
      int burst_left;
      int gap;
      command_type command;
      logic signed [VALUE_W-1:0] value;
      rsp_payload_type typed_rsp;

      req_if.valid   <= 1'b0;
      req_if.payload <= '0;

      // Refusals on empty, extremes through both ends, fill to full, refusals on full, two pops
      typed_rsp = '{popped_value: '0, status: STS_EMPTY, occupancy: 5'd0};
      add_row(CMD_POP_FRONT, 32'sh1234_5678, 1'b1, typed_rsp);
      add_row(CMD_POP_REAR, -32'sd1, 1'b1, typed_rsp);
      typed_rsp = '{popped_value: '0, status: STS_OK, occupancy: 5'd1};
      add_row(CMD_PUSH_REAR, 32'sh7fff_ffff, 1'b1, typed_rsp);
      typed_rsp = '{popped_value: '0, status: STS_OK, occupancy: 5'd2};
      add_row(CMD_PUSH_FRONT, 32'sh8000_0000, 1'b1, typed_rsp);
      typed_rsp = '{popped_value: 32'sh8000_0000, status: STS_OK, occupancy: 5'd1};
      add_row(CMD_POP_FRONT, '0, 1'b1, typed_rsp);
      typed_rsp = '{popped_value: 32'sh7fff_ffff, status: STS_OK, occupancy: 5'd0};
      add_row(CMD_POP_REAR, '0, 1'b1, typed_rsp);
      typed_rsp = '{popped_value: '0, status: STS_OK, occupancy: 5'd1};
      add_row(CMD_PUSH_FRONT, -32'sd1, 1'b1, typed_rsp);
      for (int i = 0; i < DEPTH - 1; i++)
         add_row((i % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
      typed_rsp = '{popped_value: '0, status: STS_FULL, occupancy: 5'd16};
      add_row(CMD_PUSH_REAR, 32'sh5555_5555, 1'b1, typed_rsp);
      add_row(CMD_PUSH_FRONT, 32'shaaaa_aaaa, 1'b1, typed_rsp);
      add_row(CMD_POP_REAR, $urandom);
      add_row(CMD_POP_FRONT, $urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_command(directed_rows[i].command, directed_rows[i].value);

      // Random part: phases biased toward filling, draining or balance
      phase_left = 0;
      push_pct   = 50;
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
            phase_left = $urandom_range(8, 60);
         end
         phase_left--;

         if ($urandom_range(0, 99) < push_pct)
            command = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
         else
            command = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
         case ($urandom_range(0, 15))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = '0;
            3:       value = -32'sd1;
            default: value = $urandom;
         endcase
         offer_command(command, value);

         // Gap between bursts; some bursts run long with no idling at all
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
      req_if.valid <= 1'b0;
      @(posedge clock);

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0d responses never arrived", awaited_results.size());
         mismatch_count++;
      end

      $display("Ran %0d operations: %0d words stored, %0d words returned, %0d full refusals, %s",
               accepted_requests, pushes_stored, pops_returned, full_refusals,
               $sformatf("%0d empty refusals", empty_refusals));
      $display("Checked %0d responses with %0d long response hold-offs; %0d mismatches",
               checked_responses, hold_offs_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Overall time limit
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("timeout with %0d responses outstanding", awaited_results.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_stream_if.sv
rtl/core/deq_dpath.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue_top.sv
dv/tb_double_ended_queue_top.sv
